### sv/lmfb_pkg.sv
// ----------------------------------------------------------------------------
// lmfb_pkg: shared types and constants of the LED matrix frame buffer driver
// Microcode word layout, opcode and init phase codes, chain command words.
// ----------------------------------------------------------------------------
package lmfb_pkg;

    localparam int MODULE_COUNT_DEF = 4;
    localparam int ROW_COUNT        = 8;
    localparam int ROW_W            = 32;
    localparam int CNT_W            = 3;
    localparam int PC_W             = 5;

    // command words for the module chain
    localparam logic [15:0] CMD_START_SHUTDOWN = 16'h0C00;
    localparam logic [15:0] CMD_END_SHUTDOWN   = 16'h0C01;
    localparam logic [15:0] CMD_NO_DECODE      = 16'h0900;
    localparam logic [15:0] CMD_SCAN_ALL       = 16'h0B07;
    localparam logic [15:0] CMD_INTENSITY      = 16'h0A00;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_REFRESH = 3'd1,
        OP_SCROLL  = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_WRITE   = 3'd4,
        OP_READ    = 3'd5,
        OP_BAR     = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        IPH_SHUT_ON  = 3'd0,
        IPH_CLEAR    = 3'd1,
        IPH_NODEC    = 3'd2,
        IPH_SCAN     = 3'd3,
        IPH_INTENS   = 3'd4,
        IPH_REFRESH  = 3'd5,
        IPH_SHUT_OFF = 3'd6
    } t_iph;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_IDX  = 2'd1,
        RD_CNT  = 2'd2,
        RD_REF  = 2'd3
    } t_rd;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_ROW   = 2'd1,
        WR_BAR   = 2'd2,
        WR_SHIFT = 2'd3
    } t_wr;

    typedef enum logic [2:0] {
        EM_NONE = 3'd0,
        EM_STAT = 3'd1,
        EM_READ = 3'd2,
        EM_CMD  = 3'd3,
        EM_ROW  = 3'd4
    } t_emit;

    typedef enum logic [2:0] {
        CS_SHUT_ON  = 3'd0,
        CS_SHUT_OFF = 3'd1,
        CS_NODEC    = 3'd2,
        CS_SCAN     = 3'd3,
        CS_INTENS   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        DONE_NO   = 2'd0,
        DONE_WRAP = 2'd1,
        DONE_YES  = 2'd2
    } t_done;

    typedef enum logic [1:0] {
        PH_KEEP = 2'd0,
        PH_INC  = 2'd1,
        PH_WRAP = 2'd2,
        PH_ZERO = 2'd3
    } t_ph;

    typedef struct packed {
        t_rd             rd_sel;
        t_wr             wr_sel;
        logic            clr;
        t_emit           emit;
        logic            ok_row;
        t_cmd            cmd;
        t_done           done;
        t_ph             phase;
        logic            ref_adv;
        logic            cnt_inc;
        logic            lim_mods;
        logic            loop;
        logic [PC_W-1:0] target;
        logic            fin;
    } t_uword;

    typedef struct packed {
        logic             act;
        t_uword           uw;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } t_ctrl;

endpackage

### sv/lmfb_seq.sv
// ----------------------------------------------------------------------------
// lmfb_seq: microcode sequencer
// Dispatch by opcode and init phase, program ROM, step and loop counters.
// ----------------------------------------------------------------------------
module lmfb_seq #(
    parameter int MODULE_COUNT = lmfb_pkg::MODULE_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lmfb_pkg::t_op   i_opcode,
    input  logic            i_wrap,
    output logic            o_busy,
    output lmfb_pkg::t_ctrl o_ctrl
);
    import lmfb_pkg::*;

    localparam logic [PC_W-1:0] A_NOP   = 5'd0;
    localparam logic [PC_W-1:0] A_CLR   = 5'd1;
    localparam logic [PC_W-1:0] A_WR    = 5'd2;
    localparam logic [PC_W-1:0] A_RD0   = 5'd3;
    localparam logic [PC_W-1:0] A_RD1   = 5'd4;
    localparam logic [PC_W-1:0] A_FILL  = 5'd5;
    localparam logic [PC_W-1:0] A_FILLS = 5'd6;
    localparam logic [PC_W-1:0] A_SC0   = 5'd7;
    localparam logic [PC_W-1:0] A_SC1   = 5'd8;
    localparam logic [PC_W-1:0] A_SCS   = 5'd9;
    localparam logic [PC_W-1:0] A_RF0   = 5'd10;
    localparam logic [PC_W-1:0] A_RF1   = 5'd11;
    localparam logic [PC_W-1:0] A_IP0   = 5'd12;
    localparam logic [PC_W-1:0] A_IP1   = 5'd13;
    localparam logic [PC_W-1:0] A_IP2   = 5'd14;
    localparam logic [PC_W-1:0] A_IP3   = 5'd15;
    localparam logic [PC_W-1:0] A_IP4   = 5'd16;
    localparam logic [PC_W-1:0] A_IP5A  = 5'd17;
    localparam logic [PC_W-1:0] A_IP5B  = 5'd18;
    localparam logic [PC_W-1:0] A_IP6   = 5'd19;
    localparam logic [PC_W-1:0] A_IP7   = 5'd20;

    localparam logic [CNT_W-1:0] LIM_MODS = CNT_W'(MODULE_COUNT - 1);
    localparam logic [CNT_W-1:0] LIM_ROWS = CNT_W'(ROW_COUNT - 1);

    // command loop: one word per module, ends the item
    function automatic t_uword cmd_loop(input t_cmd c, input logic [PC_W-1:0] self);
        t_uword w;
        w          = '0;
        w.emit     = EM_CMD;
        w.cmd      = c;
        w.cnt_inc  = 1'b1;
        w.lim_mods = 1'b1;
        w.loop     = 1'b1;
        w.target   = self;
        w.fin      = 1'b1;
        w.phase    = PH_INC;
        return w;
    endfunction

    function automatic t_uword rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            A_NOP: begin
                w.emit = EM_STAT;
                w.fin  = 1'b1;
            end
            A_CLR: begin
                w.clr  = 1'b1;
                w.emit = EM_STAT;
                w.fin  = 1'b1;
            end
            A_WR: begin
                w.wr_sel = WR_ROW;
                w.emit   = EM_STAT;
                w.ok_row = 1'b1;
                w.fin    = 1'b1;
            end
            A_RD0: w.rd_sel = RD_IDX;
            A_RD1: begin
                w.emit   = EM_READ;
                w.ok_row = 1'b1;
                w.fin    = 1'b1;
            end
            A_FILL: begin
                w.wr_sel  = WR_BAR;
                w.cnt_inc = 1'b1;
                w.loop    = 1'b1;
                w.target  = A_FILL;
            end
            A_SC0: w.rd_sel = RD_CNT;
            A_SC1: begin
                w.wr_sel  = WR_SHIFT;
                w.cnt_inc = 1'b1;
                w.loop    = 1'b1;
                w.target  = A_SC0;
            end
            A_FILLS, A_SCS: begin
                w.emit = EM_STAT;
                w.fin  = 1'b1;
            end
            A_RF0, A_IP5A: w.rd_sel = RD_REF;
            A_RF1, A_IP5B: begin
                w.emit     = EM_ROW;
                w.cnt_inc  = 1'b1;
                w.lim_mods = 1'b1;
                w.loop     = 1'b1;
                w.target   = pc;
                w.fin      = 1'b1;
                w.ref_adv  = 1'b1;
                w.done     = (pc == A_RF1) ? DONE_WRAP : DONE_NO;
                w.phase    = (pc == A_RF1) ? PH_KEEP : PH_WRAP;
            end
            A_IP0: w = cmd_loop(CS_SHUT_ON, A_IP0);
            A_IP1: begin
                w.clr   = 1'b1;
                w.emit  = EM_STAT;
                w.fin   = 1'b1;
                w.phase = PH_INC;
            end
            A_IP2: w = cmd_loop(CS_NODEC, A_IP2);
            A_IP3: w = cmd_loop(CS_SCAN, A_IP3);
            A_IP4: w = cmd_loop(CS_INTENS, A_IP4);
            A_IP6: begin
                w       = cmd_loop(CS_SHUT_OFF, A_IP6);
                w.done  = DONE_YES;
                w.phase = PH_ZERO;
            end
            A_IP7: begin
                w.emit  = EM_STAT;
                w.fin   = 1'b1;
                w.phase = PH_ZERO;
            end
            default: begin
                w.emit = EM_STAT;
                w.fin  = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry(input t_op op, input t_iph ph);
        logic [PC_W-1:0] a;
        a = A_NOP;
        unique case (op)
            OP_INIT: begin
                unique case (ph)
                    IPH_SHUT_ON:  a = A_IP0;
                    IPH_CLEAR:    a = A_IP1;
                    IPH_NODEC:    a = A_IP2;
                    IPH_SCAN:     a = A_IP3;
                    IPH_INTENS:   a = A_IP4;
                    IPH_REFRESH:  a = A_IP5A;
                    IPH_SHUT_OFF: a = A_IP6;
                    default:      a = A_IP7;
                endcase
            end
            OP_REFRESH: a = A_RF0;
            OP_SCROLL:  a = A_SC0;
            OP_CLEAR:   a = A_CLR;
            OP_WRITE:   a = A_WR;
            OP_READ:    a = A_RD0;
            OP_BAR:     a = A_FILL;
            default:    a = A_NOP;
        endcase
        return a;
    endfunction

    logic             r_busy;
    logic [PC_W-1:0]  r_pc;
    logic [CNT_W-1:0] r_cnt;
    t_iph             r_phase;
    t_uword           uw;
    logic             at_lim;
    logic             step_last;

    assign uw        = rom(r_pc);
    assign at_lim    = (r_cnt == (uw.lim_mods ? LIM_MODS : LIM_ROWS));
    assign step_last = r_busy && uw.fin && (!uw.loop || at_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= A_NOP;
            r_cnt   <= '0;
            r_phase <= IPH_SHUT_ON;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pc   <= entry(i_opcode, r_phase);
                r_cnt  <= '0;
            end
        end else begin
            if (uw.cnt_inc) begin
                r_cnt <= at_lim ? '0 : r_cnt + 1'b1;
            end
            if (step_last) begin
                r_busy <= 1'b0;
                unique case (uw.phase)
                    PH_KEEP: r_phase <= r_phase;
                    PH_INC:  r_phase <= t_iph'(r_phase + 3'd1);
                    PH_WRAP: r_phase <= i_wrap ? t_iph'(r_phase + 3'd1) : r_phase;
                    PH_ZERO: r_phase <= IPH_SHUT_ON;
                    default: r_phase <= IPH_SHUT_ON;
                endcase
            end else if (uw.loop && !at_lim) begin
                r_pc <= uw.target;
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_ctrl.act  = r_busy;
    assign o_ctrl.uw   = uw;
    assign o_ctrl.cnt  = r_cnt;
    assign o_ctrl.last = step_last;

endmodule

### sv/lmfb_dp.sv
// ----------------------------------------------------------------------------
// lmfb_dp: frame buffer datapath
// Row memory with valid bits, operand latch, shifter, word builder, result
// register.
// ----------------------------------------------------------------------------
module lmfb_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic [7:0]      i_row_index,
    input  logic [31:0]     i_row_value,
    input  logic [7:0]      i_shift_count,
    input  logic [15:0]     i_fill_width,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_wdata,
    input  lmfb_pkg::t_ctrl i_ctrl,
    output logic            o_wrap,
    output logic            o_res_valid,
    output logic [15:0]     o_serial_word,
    output logic            o_word_valid,
    output logic [31:0]     o_read_value,
    output logic            o_ok,
    output logic            o_done_res,
    output logic            o_last
);
    import lmfb_pkg::*;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    localparam int RA_W = $clog2(ROW_COUNT);

    logic [ROW_W-1:0]     r_mem [ROW_COUNT];
    logic [ROW_COUNT-1:0] r_valid;
    logic [ROW_W-1:0]     r_rdata;
    logic                 r_rvalid;
    logic [RA_W-1:0]      r_ref;
    logic [3:0]           r_bright;

    // operands held for the whole item
    logic [7:0]           r_row_idx;
    logic [31:0]          r_row_val;
    logic [7:0]           r_shift;
    logic [15:0]          r_fill;

    logic                 r_strobe;
    logic [15:0]          r_word;
    logic                 r_wvalid;
    logic [31:0]          r_rd_out;
    logic                 r_ok;
    logic                 r_done;
    logic                 r_last;

    t_uword               uw;
    logic                 row_ok;
    logic [ROW_W-1:0]     eff;
    logic [ROW_W-1:0]     shifted;
    logic [ROW_W-1:0]     bar;
    logic [RA_W-1:0]      raddr;
    logic [RA_W-1:0]      waddr;
    logic [ROW_W-1:0]     wdata;
    logic                 we;
    logic [7:0]           data_byte;
    logic [7:0]           addr_byte;
    logic [15:0]          cmd_word;
    logic [15:0]          n_word;
    logic                 n_strobe;
    logic                 n_done;

    assign uw     = i_ctrl.uw;
    assign row_ok = (r_row_idx[7:RA_W] == '0);
    assign eff    = r_rvalid ? r_rdata : '0;
    assign o_wrap = (r_ref == RA_W'(ROW_COUNT - 1));

    assign shifted = (r_shift[7:5] != '0) ? '0 : (eff << r_shift[4:0]);
    assign bar     = (r_fill[15:5] != '0) ? '1 : ((ROW_W'(1) << r_fill[4:0]) - 1'b1);

    always_comb begin
        unique case (uw.rd_sel)
            RD_IDX:  raddr = r_row_idx[RA_W-1:0];
            RD_REF:  raddr = r_ref;
            default: raddr = i_ctrl.cnt[RA_W-1:0];
        endcase
    end

    always_comb begin
        waddr = i_ctrl.cnt[RA_W-1:0];
        wdata = bar;
        we    = 1'b0;
        unique case (uw.wr_sel)
            WR_ROW: begin
                waddr = r_row_idx[RA_W-1:0];
                wdata = r_row_val;
                we    = i_ctrl.act && row_ok;
            end
            WR_BAR: begin
                we = i_ctrl.act;
            end
            WR_SHIFT: begin
                wdata = shifted;
                we    = i_ctrl.act;
            end
            default: we = 1'b0;
        endcase
    end

    // memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_ctrl.act && uw.rd_sel != RD_NONE) begin
            r_rdata  <= r_mem[raddr];
            r_rvalid <= r_valid[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ref    <= '0;
            r_bright <= '0;
        end else begin
            if (i_cfg_we) begin
                r_bright <= i_cfg_wdata;
            end
            if (i_ctrl.act && uw.clr) begin
                r_valid <= '0;
            end else if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (i_ctrl.last && uw.ref_adv) begin
                r_ref <= r_ref + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row_idx <= i_row_index;
            r_row_val <= i_row_value;
            r_shift   <= i_shift_count;
            r_fill    <= i_fill_width;
        end
    end

    assign data_byte = i_ctrl.cnt[CNT_W-1] ? 8'h00 : eff[8*i_ctrl.cnt[1:0] +: 8];
    assign addr_byte = 8'(ROW_COUNT) - 8'(r_ref);

    always_comb begin
        unique case (uw.cmd)
            CS_SHUT_ON:  cmd_word = CMD_START_SHUTDOWN;
            CS_SHUT_OFF: cmd_word = CMD_END_SHUTDOWN;
            CS_NODEC:    cmd_word = CMD_NO_DECODE;
            CS_SCAN:     cmd_word = CMD_SCAN_ALL;
            CS_INTENS:   cmd_word = CMD_INTENSITY | {12'h000, r_bright};
            default:     cmd_word = CMD_START_SHUTDOWN;
        endcase
    end

    always_comb begin
        unique case (uw.emit)
            EM_CMD:  n_word = cmd_word;
            EM_ROW:  n_word = {addr_byte, rev8(data_byte)};
            default: n_word = '0;
        endcase
    end

    always_comb begin
        unique case (uw.done)
            DONE_WRAP: n_done = o_wrap;
            DONE_YES:  n_done = 1'b1;
            default:   n_done = 1'b0;
        endcase
    end

    assign n_strobe = i_ctrl.act && (uw.emit != EM_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_word   <= n_word;
            r_wvalid <= (uw.emit == EM_CMD) || (uw.emit == EM_ROW);
            r_rd_out <= (uw.emit == EM_READ && row_ok) ? eff : '0;
            r_ok     <= uw.ok_row ? row_ok : 1'b1;
            r_done   <= i_ctrl.last && n_done;
            r_last   <= i_ctrl.last;
        end
    end

    assign o_res_valid   = r_strobe;
    assign o_serial_word = r_word;
    assign o_word_valid  = r_wvalid;
    assign o_read_value  = r_rd_out;
    assign o_ok          = r_ok;
    assign o_done_res    = r_done;
    assign o_last        = r_last;

endmodule

### sv/led_matrix_frame_buffer_driver.sv
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer_driver: frame buffer and word generator for a chain
// of cascaded 8x8 LED modules
// Keeps 8 rows of 32 columns and turns init and refresh steps into 16-bit
// address/data words, one per module, module 0 first.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low; busy then
// stays high while a small microprogram runs, one step per cycle. Results
// leave on o_res_valid for exactly one cycle each, in consecutive cycles for
// a multi-word item, with o_last on the final one; the receiver cannot hold
// them off, so it must take a transfer in every strobed cycle. Per item,
// an init command step emits one word per module; the init clear phase,
// clear, write row and unused codes one status result; refresh and the init
// refresh phase a registered row read, then one word per module; read row a
// registered read, then the result; bar fill a write of each row (one row
// write per cycle), then status; scroll a read and write per row, then
// status. The next item is taken in the cycle after busy falls, while the
// last result is still on the ports. The brightness register is written at
// any edge with i_cfg_we high; write it only while the block is idle. No
// clearing pass after reset: rows carry valid bits.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_driver #(
    parameter int MODULE_COUNT = lmfb_pkg::MODULE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_row_index,
    input  logic [31:0] i_row_value,
    input  logic [7:0]  i_shift_count,
    input  logic [15:0] i_fill_width,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    output logic        o_res_valid,
    output logic [15:0] o_serial_word,
    output logic        o_word_valid,
    output logic [31:0] o_read_value,
    output logic        o_ok,
    output logic        o_done_res,
    output logic        o_last
);
    import lmfb_pkg::*;

    t_ctrl ctrl;      // current microcode step, loop count, end of item
    logic  wrap;      // refresh pointer sits on the last row
    logic  load;      // input transfer

    assign load = start && !busy;

    lmfb_seq #(
        .MODULE_COUNT(MODULE_COUNT)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (t_op'(i_opcode)),
        .i_wrap   (wrap),
        .o_busy   (busy),
        .o_ctrl   (ctrl)
    );

    // datapath latches the operands on the transfer and follows the program
    lmfb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_row_index   (i_row_index),
        .i_row_value   (i_row_value),
        .i_shift_count (i_shift_count),
        .i_fill_width  (i_fill_width),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_ctrl        (ctrl),
        .o_wrap        (wrap),
        .o_res_valid   (o_res_valid),
        .o_serial_word (o_serial_word),
        .o_word_valid  (o_word_valid),
        .o_read_value  (o_read_value),
        .o_ok          (o_ok),
        .o_done_res    (o_done_res),
        .o_last        (o_last)
    );

endmodule

### sv/lmfb_chk.sv
// ----------------------------------------------------------------------------
// lmfb_chk: port-level checks of the LED matrix frame buffer driver
// Burst framing, end of item and result field consistency.
// ----------------------------------------------------------------------------
module lmfb_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_res_valid,
    input logic        o_word_valid,
    input logic [31:0] o_read_value,
    input logic        o_ok,
    input logic        o_done_res,
    input logic        o_last
);

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transfer did not start the sequencer");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_res_valid && o_last)
        else $error("item ended without a final result");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_last |=> o_res_valid)
        else $error("gap inside a result burst");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_done_res |-> o_last && o_word_valid)
        else $error("done outside the final serial word");

    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_read_value != '0) |-> o_ok && !o_word_valid && o_last)
        else $error("read data on a non-read result");

endmodule

bind led_matrix_frame_buffer_driver lmfb_chk u_lmfb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_valid  (o_res_valid),
    .o_word_valid (o_word_valid),
    .o_read_value (o_read_value),
    .o_ok         (o_ok),
    .o_done_res   (o_done_res),
    .o_last       (o_last)
);
